/* hdl/ufcc_pkg.sv */
// ----------------------------------------------------------------------------
// ufcc_pkg
// shared widths and defaults for the union-find component counter
// ----------------------------------------------------------------------------
package ufcc_pkg;

    // node index width on the input ports
    localparam int NODE_W = 10;
    // width of node count and component count
    localparam int COUNT_W = 11;
    // default size of the parent link memory
    localparam int DEFAULT_MAX_NODES = 1024;

    typedef logic [NODE_W-1:0]  t_node;
    typedef logic [COUNT_W-1:0] t_count;

endpackage

/* hdl/union_find_component_counter.sv */
// ----------------------------------------------------------------------------
// union_find_component_counter
// disjoint-set engine with path compression and a running component count
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready) carries one edge per item: i_node_a and
//   i_node_b. the root of node_b is linked under the root of node_a when the
//   two differ, and the component count drops by one.
//   output channel (o_valid / i_ready) carries one result item per edge:
//   o_component_count, o_merged and o_index_error.
//   config port: i_cfg_we / i_cfg_wdata write node_count (clamped to
//   1..MAX_NODES); every write re-initializes all sets.
// sequencing
//   one item at a time. an edge walks the parent chain from each node to its
//   root, first a root walk and then a compression walk; each step is one read
//   of the parent memory. an item with a bad index skips the walks and goes
//   straight to the result.
// reset
//   after reset, and after every config write, a clearing pass writes each
//   of the MAX_NODES memory entries as its own root, one per cycle; o_ready
//   stays low until the pass is done. config writes are taken at any time.
// stall
//   the result sits in an output register; the next edge is accepted while it
//   waits, and the engine holds its finished result until that register frees.
// ----------------------------------------------------------------------------
module union_find_component_counter
    import ufcc_pkg::*;
#(
    parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    // edge input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [NODE_W-1:0]  i_node_a,
    input  logic [NODE_W-1:0]  i_node_b,
    // result output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COUNT_W-1:0] o_component_count,
    output logic               o_merged,
    output logic               o_index_error
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    // largest node count: MAX_NODES, capped at what the count width can hold
    localparam t_count CNT_MAX = (MAX_NODES > (2**COUNT_W - 1)) ?
                                 {COUNT_W{1'b1}} : COUNT_W'(MAX_NODES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

    typedef logic [AW-1:0] t_idx;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,  // memory init sweep
        S_IDLE  = 6'b000010,  // waiting for an edge
        S_UP    = 6'b000100,  // walk up to the root
        S_CMP   = 6'b001000,  // walk again, pointing nodes at the root
        S_LINK  = 6'b010000,  // link roots, update count
        S_DONE  = 6'b100000   // hand result to output register
    } t_state;

    t_state r_state, n_state;

    // parent link memory, registered read
    t_idx r_mem [MAX_NODES];
    t_idx r_rd_data;
    t_idx rd_addr;
    logic mem_we;
    t_idx wr_addr;
    t_idx wr_data;

    t_idx   r_clr_idx, n_clr_idx;
    t_count r_node_count, n_node_count;
    t_count r_comp_left, n_comp_left;

    t_idx r_node_b, n_node_b;
    t_idx r_start, n_start;
    t_idx r_cur, n_cur;
    t_idx r_root, n_root;
    t_idx r_root_a, n_root_a;
    logic r_phase_b, n_phase_b;
    logic r_res_merged, n_res_merged;
    logic r_res_err, n_res_err;

    logic   r_out_valid, n_out_valid;
    t_count r_out_count, n_out_count;
    logic   r_out_merged, n_out_merged;
    logic   r_out_err, n_out_err;

    t_count cfg_sat;
    logic   in_accept;
    logic   bad_index;

    assign o_ready           = (r_state == S_IDLE);
    assign in_accept         = i_valid && o_ready;
    assign o_valid           = r_out_valid;
    assign o_component_count = r_out_count;
    assign o_merged          = r_out_merged;
    assign o_index_error     = r_out_err;

    // clamp written node count to 1..MAX_NODES
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_sat = COUNT_W'(1);
        end else if (i_cfg_wdata > CNT_MAX) begin
            cfg_sat = CNT_MAX;
        end else begin
            cfg_sat = i_cfg_wdata;
        end
    end

    // either endpoint outside the nodes in use
    assign bad_index = ({1'b0, i_node_a} >= r_node_count) ||
                       ({1'b0, i_node_b} >= r_node_count);

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_node_count = r_node_count;
        n_comp_left  = r_comp_left;
        n_node_b     = r_node_b;
        n_start      = r_start;
        n_cur        = r_cur;
        n_root       = r_root;
        n_root_a     = r_root_a;
        n_phase_b    = r_phase_b;
        n_res_merged = r_res_merged;
        n_res_err    = r_res_err;
        n_out_valid  = r_out_valid;
        n_out_count  = r_out_count;
        n_out_merged = r_out_merged;
        n_out_err    = r_out_err;
        rd_addr      = r_cur;
        mem_we       = 1'b0;
        wr_addr      = r_cur;
        wr_data      = r_root;

        // output register drains independently of the sequencer
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_idx;
                wr_data = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (bad_index) begin
                        n_res_err    = 1'b1;
                        n_res_merged = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        n_res_err = 1'b0;
                        n_node_b  = AW'(i_node_b);
                        n_start   = AW'(i_node_a);
                        n_cur     = AW'(i_node_a);
                        rd_addr   = AW'(i_node_a);
                        n_phase_b = 1'b0;
                        n_state   = S_UP;
                    end
                end
            end
            S_UP: begin
                // r_rd_data holds the parent of r_cur
                if (r_rd_data == r_cur) begin
                    n_root  = r_cur;
                    n_cur   = r_start;
                    rd_addr = r_start;
                    n_state = S_CMP;
                end else begin
                    n_cur   = r_rd_data;
                    rd_addr = r_rd_data;
                end
            end
            S_CMP: begin
                if (r_cur == r_root) begin
                    if (!r_phase_b) begin
                        n_root_a  = r_root;
                        n_phase_b = 1'b1;
                        n_start   = r_node_b;
                        n_cur     = r_node_b;
                        rd_addr   = r_node_b;
                        n_state   = S_UP;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    // point visited node straight at its root
                    mem_we  = 1'b1;
                    wr_addr = r_cur;
                    wr_data = r_root;
                    n_cur   = r_rd_data;
                    rd_addr = r_rd_data;
                end
            end
            S_LINK: begin
                if (r_root != r_root_a) begin
                    mem_we       = 1'b1;
                    wr_addr      = r_root;
                    wr_data      = r_root_a;
                    n_res_merged = 1'b1;
                    if (r_comp_left != '0) begin
                        n_comp_left = r_comp_left - 1'b1;
                    end
                end else begin
                    n_res_merged = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = r_comp_left;
                    n_out_merged = r_res_merged;
                    n_out_err    = r_res_err;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // config write re-initializes all sets
        if (i_cfg_we) begin
            n_node_count = cfg_sat;
            n_comp_left  = cfg_sat;
            n_clr_idx    = '0;
            n_state      = S_CLEAR;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_node_count <= CNT_MAX;
            r_comp_left  <= CNT_MAX;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr_idx    <= n_clr_idx;
            r_node_count <= n_node_count;
            r_comp_left  <= n_comp_left;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_node_b     <= n_node_b;
        r_start      <= n_start;
        r_cur        <= n_cur;
        r_root       <= n_root;
        r_root_a     <= n_root_a;
        r_phase_b    <= n_phase_b;
        r_res_merged <= n_res_merged;
        r_res_err    <= n_res_err;
        r_out_count  <= n_out_count;
        r_out_merged <= n_out_merged;
        r_out_err    <= n_out_err;
    end

    // parent link memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule

/* hdl/ufcc_checker.sv */
// ----------------------------------------------------------------------------
// ufcc_checker
// port-level checks for the union-find component counter
// ----------------------------------------------------------------------------
module ufcc_checker
    import ufcc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [COUNT_W-1:0] o_component_count,
    input logic               o_merged,
    input logic               o_index_error
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_component_count) &&
                                $stable(o_merged) && $stable(o_index_error))
        else $error("stalled result changed");

    // a bad index never merges
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> !o_merged)
        else $error("merge reported with index error");

    // at least one component always remains
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_component_count != '0)
        else $error("component count is zero");

    // config write starts the init sweep, input closed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("input open right after config write");

endmodule

bind union_find_component_counter ufcc_checker u_ufcc_checker (.*);

/* tb/tb_union_find_component_counter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_union_find_component_counter
// self-checking bench for the union-find component counter: edges go in over
// a valid/ready channel and each result item is checked against a software
// disjoint-set forest with path compression kept inside the bench
// ----------------------------------------------------------------------------
module tb_union_find_component_counter;
    import ufcc_pkg::*;

    localparam int MAX_NODES     = DEFAULT_MAX_NODES;
    // longest gap without any handshake: a clearing pass after a config
    // write plus a worst-case chain walk fit many times over
    localparam int STALL_LIMIT   = 20000;
    // quiet cycles before a config write and at the end of the run
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    // random part: segments with their own node count and idling mix
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 125;
    localparam int CHAIN_MAX     = 40;

    typedef struct packed {
        t_count count;
        logic   merged;
        logic   index_error;
    } t_edge_result;

    // dut ports, all inputs known from time zero
    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_we    = 1'b0;
    t_count       i_cfg_wdata = '0;
    logic         i_valid     = 1'b0;
    logic         o_ready;
    t_node        i_node_a    = '0;
    t_node        i_node_b    = '0;
    logic         o_valid;
    logic         i_ready     = 1'b0;
    t_count       o_component_count;
    logic         o_merged;
    logic         o_index_error;

    // software forest mirroring the block state
    t_count       forest_parent [MAX_NODES];
    int unsigned  forest_node_count;
    int unsigned  forest_components;

    // results predicted at input acceptance, oldest first
    t_edge_result pending_results [$];

    int unsigned  mismatches     = 0;
    int unsigned  quiet_cycles   = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;

    union_find_component_counter #(
        .MAX_NODES(MAX_NODES)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_node_a         (i_node_a),
        .i_node_b         (i_node_b),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_component_count(o_component_count),
        .o_merged         (o_merged),
        .o_index_error    (o_index_error)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // forest model
    // ------------------------------------------------------------------

    // clamp to 1..MAX_NODES, then every node becomes its own root
    function automatic void forest_configure(input t_count value);
        int unsigned v;
        v = value;
        if (v < 1) v = 1;
        if (v > MAX_NODES) v = MAX_NODES;
        forest_node_count = v;
        for (int i = 0; i < MAX_NODES; i++) forest_parent[i] = t_count'(i);
        forest_components = v;
    endfunction

    // walk up to the root, then point every node on the path at it
    function automatic int unsigned forest_root(input int unsigned node);
        int unsigned root;
        int unsigned next;
        int unsigned steps;
        root  = node;
        steps = 0;
        while (forest_parent[root] != root && steps < MAX_NODES) begin
            root = forest_parent[root] % MAX_NODES;
            steps++;
        end
        steps = 0;
        while (node != root && steps < MAX_NODES) begin
            next = forest_parent[node] % MAX_NODES;
            forest_parent[node] = t_count'(root);
            node = next;
            steps++;
        end
        return root;
    endfunction

    // one edge: bad index leaves everything alone, else root of b goes under
    // root of a when they differ
    function automatic t_edge_result forest_apply_edge(input int unsigned a,
                                                       input int unsigned b);
        t_edge_result res;
        int unsigned  root_a;
        int unsigned  root_b;
        res.merged      = 1'b0;
        res.index_error = 1'b0;
        if (a >= forest_node_count || b >= forest_node_count) begin
            res.index_error = 1'b1;
        end else begin
            root_a = forest_root(a);
            root_b = forest_root(b);
            if (root_a != root_b) begin
                forest_parent[root_b] = t_count'(root_a);
                if (forest_components > 0) forest_components--;
                res.merged = 1'b1;
            end
        end
        res.count = t_count'(forest_components);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // receiver side: random stalls on i_ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result check: every accepted result item against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_edge_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing pending: count %0d merged %0d error %0d",
                       o_component_count, o_merged, o_index_error);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_component_count !== want.count) begin
                    $error("component_count: expected %0d, got %0d",
                           want.count, o_component_count);
                    mismatches++;
                end
                if (o_merged !== want.merged) begin
                    $error("merged: expected %0d, got %0d", want.merged, o_merged);
                    mismatches++;
                end
                if (o_index_error !== want.index_error) begin
                    $error("index_error: expected %0d, got %0d",
                           want.index_error, o_index_error);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one edge item; prediction is taken at the accepting edge so the
    // expected queue follows acceptance order
    task automatic send_edge(input int unsigned a, input int unsigned b);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_node_a <= a[NODE_W-1:0];
        i_node_b <= b[NODE_W-1:0];
        i_valid  <= 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(forest_apply_edge(a, b));
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // config write only with the block drained and settled
    task automatic write_node_count(input t_count value);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        forest_configure(value);
    endtask

    // node count for a random segment: mostly small, some full size, some
    // above the top so the clamp is exercised
    function automatic t_count pick_node_count(input int unsigned seg);
        case (seg % 6)
            0:       return t_count'($urandom_range(2, 16));
            1:       return t_count'($urandom_range(17, 64));
            2:       return t_count'(MAX_NODES);
            3:       return t_count'($urandom_range(65, MAX_NODES - 1));
            4:       return t_count'($urandom_range(2, 8));
            default: return t_count'($urandom_range(MAX_NODES + 1, 2047));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default node count after reset, corner node indexes
    task automatic test_after_reset();
        send_edge(0, MAX_NODES - 1);        // merge across the full range
        send_edge(MAX_NODES - 1, 0);        // same component, reversed
        send_edge(7, 7);                    // self edge
        send_edge(682, 341);                // alternating index bits
    endtask

    // clamp of the node count register at both ends
    task automatic test_register_extremes();
        write_node_count(t_count'(0));      // clamps to one node
        send_edge(0, 0);
        send_edge(1, 0);                    // only node 0 exists
        write_node_count(t_count'(2047));   // clamps to full size
        send_edge(MAX_NODES - 1, 1);
        write_node_count(t_count'(2));
        send_edge(1, 0);                    // count reaches one
        send_edge(0, 1);
    endtask

    // index at or beyond node count on either side
    task automatic test_index_errors();
        write_node_count(t_count'(10));
        send_edge(10, 3);
        send_edge(3, 10);
        send_edge(MAX_NODES - 1, MAX_NODES - 1);
        send_edge(9, 0);
    endtask

    // each edge puts the old tree under a new root, so the chain from node 0
    // grows by one per edge; the final edge compresses the whole chain
    task automatic test_deep_chain();
        write_node_count(t_count'(10));
        for (int i = 0; i < 9; i++) send_edge(i + 1, i);
        send_edge(0, 9);
    endtask

    // random edges in segments, each with its own node count and idling mix
    task automatic test_random_forests();
        int unsigned seg;
        int unsigned made;
        int unsigned nc;
        int unsigned pick;
        int unsigned bad;
        int unsigned len;
        int unsigned start;
        for (seg = 0; seg < SEGMENTS; seg++) begin
            write_node_count(pick_node_count(seg));
            nc = forest_node_count;
            case (seg % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            made = 0;
            while (made < SEGMENT_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 15 && nc < MAX_NODES) begin
                    // noise: one or both indexes out of range
                    bad = $urandom_range(nc, MAX_NODES - 1);
                    case ($urandom_range(0, 2))
                        0:       send_edge(bad, $urandom_range(0, nc - 1));
                        1:       send_edge($urandom_range(0, nc - 1), bad);
                        default: send_edge(bad, $urandom_range(nc, MAX_NODES - 1));
                    endcase
                    made++;
                end else if (pick < 35 && nc >= 3) begin
                    // build a chain over consecutive nodes, then query its ends
                    len   = $urandom_range(2, (nc - 1 < CHAIN_MAX) ? nc - 1 : CHAIN_MAX);
                    start = $urandom_range(0, nc - 1 - len);
                    for (int i = 0; i < len; i++) send_edge(start + i + 1, start + i);
                    if ($urandom_range(0, 1)) send_edge(start, start + len);
                    else send_edge(start + len, start);
                    made += len + 1;
                end else begin
                    send_edge($urandom_range(0, nc - 1), $urandom_range(0, nc - 1));
                    made++;
                end
                // now and then let the pipeline run dry
                if ($urandom_range(0, 99) == 0) wait_all_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // run
    // ------------------------------------------------------------------
    initial begin
        forest_configure(t_count'(MAX_NODES));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_register_extremes();
        test_index_errors();
        test_deep_chain();
        test_random_forests();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
